// ===== rtl/core/srf_pkg.sv =====
package srf_pkg;

	// Field widths
	localparam int POS_W      = 9;
	localparam int SAMPLE_W   = 16;
	localparam int OUT_W      = 24;
	localparam int ROWIDX_W   = 10;
	localparam int WIDTH_W    = 10;
	localparam int ANGLE_W    = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	// Scan counter: holds up to row_width + 1
	localparam int SCAN_W = 11;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_COUNT = 1'd1;

	// Register reset values
	localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST   = 10'd512;
	localparam logic [ANGLE_W-1:0] ANGLE_COUNT_RST = 11'd180;
	localparam logic [ANGLE_W-1:0] ANGLE_LIMIT     = 11'd1024;

	// Taps: Q22. Odd offsets n carry -((2*RECIP + n^2) / (2*n^2)).
	localparam longint unsigned RECIP_PI2_Q22 = 424972;
	localparam int MAG_W  = 19;
	localparam int TAP_W  = 21;
	localparam logic [TAP_W-1:0] TAP_CENTER = 21'h100000;

	// Arithmetic
	localparam int PROD_W    = SAMPLE_W + TAP_W;
	localparam int ACC_W     = 40;
	localparam int FRAC_DROP = 14;
	localparam logic signed [OUT_W-1:0] OUT_MAX_V = 24'sh7FFFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN_V = 24'sh800000;

	// Controller to datapath
	typedef struct packed {
		logic wr_sample;
		logic start;
		logic issue_center;
		logic issue_scan;
		logic finish;
	} srf_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pos_in_range;
		logic scan_more;
		logic pipe_busy;
	} srf_stat_t;

endpackage

// ===== rtl/core/srf_if.sv =====
interface srf_in_if import srf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                action;
	logic [POS_W-1:0]    position;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, action, position, sample, input ready);
	modport sink   (input valid, action, position, sample, output ready);
endinterface

interface srf_out_if import srf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] filtered_value;
	logic [POS_W-1:0]        out_position;
	logic [ROWIDX_W-1:0]     row_index;

	modport source (output valid, filtered_value, out_position, row_index, input ready);
	modport sink   (input valid, filtered_value, out_position, row_index, output ready);
endinterface

interface srf_cfg_if import srf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/srf_ctrl.sv =====
module srf_ctrl import srf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_action,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  srf_stat_t stat,
	output srf_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CENTER,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Commands
	always_comb begin
		cmd.wr_sample    = accept && !in_action && stat.pos_in_range;
		cmd.start        = accept && in_action && stat.pos_in_range;
		cmd.issue_center = (state_q == ST_CENTER);
		cmd.issue_scan   = (state_q == ST_SCAN) && stat.scan_more;
		cmd.finish       = (state_q == ST_DRAIN) && !stat.pipe_busy && out_free;
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) state_q <= ST_CENTER;
				end
				ST_CENTER: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (!stat.scan_more) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (cmd.finish) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/srf_datapath.sv =====
module srf_datapath import srf_pkg::*; #(
	parameter int ROW_MAX = 512
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  srf_cmd_t                cmd,
	output srf_stat_t               stat,
	input  logic [POS_W-1:0]        position,
	input  logic [SAMPLE_W-1:0]     sample,
	input  logic                    cfg_valid,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic signed [OUT_W-1:0] filtered_value,
	output logic [POS_W-1:0]        out_position,
	output logic [ROWIDX_W-1:0]     row_index
);

	localparam int AW        = $clog2(ROW_MAX);
	localparam int TAPS      = ROW_MAX / 2;
	localparam int KW        = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int TAP_DEPTH = 1 << KW;
	localparam int WMAX      = (ROW_MAX < 1023) ? ROW_MAX : 1023;
	localparam logic [WIDTH_W-1:0]    WMAX_V   = WIDTH_W'(WMAX);
	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(8192);
	localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(OUT_MAX_V);
	localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(OUT_MIN_V);

	// Configuration and row counter
	logic [WIDTH_W-1:0]  row_width_q;
	logic [ANGLE_W-1:0]  angle_count_q;
	logic [ROWIDX_W-1:0] row_cnt_q;
	logic [WIDTH_W-1:0]  eff_w;
	logic [ANGLE_W-1:0]  eff_ang;
	logic                in_last;

	// Current read
	logic [POS_W-1:0]    pos_q;
	logic [ROWIDX_W-1:0] row_q;
	logic [SCAN_W-1:0]   m_q;
	logic [SCAN_W-1:0]   pos_w;
	logic [SCAN_W-1:0]   off;

	// Store and taps
	logic [SAMPLE_W-1:0] row_store [ROW_MAX];
	logic [MAG_W-1:0]    tap_rom [TAP_DEPTH];
	logic [AW+POS_W-1:0] wr_addr_x;
	logic [AW+POS_W-1:0] ctr_addr_x;
	logic [AW+SCAN_W-1:0] m_addr_x;
	logic [KW+SCAN_W-2:0] k_x;
	logic [AW-1:0]       rd_addr;
	logic [KW-1:0]       k_idx;
	logic                rd_en;

	// Pipeline
	logic                    vld_s1, vld_s2;
	logic                    center_s1, center_s2;
	logic [SAMPLE_W-1:0]     sample_s1;
	logic [TAP_W-1:0]        tap_s1;
	logic [PROD_W-1:0]       prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] rnd_sum;
	logic signed [ACC_W-1:0] rnd_q8;
	logic signed [OUT_W-1:0] sat_val;

	// Clamped register values
	always_comb begin
		if (row_width_q == '0) eff_w = WIDTH_W'(1);
		else if (row_width_q > WMAX_V) eff_w = WMAX_V;
		else eff_w = row_width_q;

		if (angle_count_q == '0) eff_ang = ANGLE_W'(1);
		else if (angle_count_q > ANGLE_LIMIT) eff_ang = ANGLE_LIMIT;
		else eff_ang = angle_count_q;
	end

	assign in_last = ({1'b0, position} == (eff_w - WIDTH_W'(1)));

	// Status
	assign stat.pos_in_range = ({1'b0, position} < eff_w);
	assign stat.scan_more    = (m_q < {1'b0, eff_w});
	assign stat.pipe_busy    = vld_s1 || vld_s2;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q   <= ROW_WIDTH_RST;
			angle_count_q <= ANGLE_COUNT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROW_WIDTH:   row_width_q   <= cfg_data[WIDTH_W-1:0];
				REG_ANGLE_COUNT: angle_count_q <= cfg_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Row counter advances on a read of the last position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= '0;
		end else if (cmd.start && in_last) begin
			if (({1'b0, row_cnt_q} + ANGLE_W'(1)) >= eff_ang) row_cnt_q <= '0;
			else row_cnt_q <= row_cnt_q + ROWIDX_W'(1);
		end
	end

	// Read context and scan counter: only opposite-parity positions have nonzero taps
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pos_q <= position;
			row_q <= row_cnt_q;
			m_q   <= {{(SCAN_W-1){1'b0}}, ~position[0]};
		end else if (cmd.issue_scan) begin
			m_q <= m_q + SCAN_W'(2);
		end
	end

	// Addresses
	assign pos_w      = {{(SCAN_W-POS_W){1'b0}}, pos_q};
	assign off        = (m_q >= pos_w) ? (m_q - pos_w) : (pos_w - m_q);
	assign k_x        = {{KW{1'b0}}, off[SCAN_W-1:1]};
	assign k_idx      = k_x[KW-1:0];
	assign wr_addr_x  = {{AW{1'b0}}, position};
	assign ctr_addr_x = {{AW{1'b0}}, pos_q};
	assign m_addr_x   = {{AW{1'b0}}, m_q};
	assign rd_addr    = cmd.issue_center ? ctr_addr_x[AW-1:0] : m_addr_x[AW-1:0];
	assign rd_en      = cmd.issue_center || cmd.issue_scan;

	// Tap magnitudes for odd offsets 2k+1
	for (genvar k = 0; k < TAP_DEPTH; k++) begin : g_tap
		localparam longint unsigned N   = 2 * k + 1;
		localparam longint unsigned MAG = (2 * RECIP_PI2_Q22 + N * N) / (2 * N * N);
		assign tap_rom[k] = MAG_W'(MAG);
	end

	// Row store
	always_ff @(posedge clk) begin
		if (cmd.wr_sample) row_store[wr_addr_x[AW-1:0]] <= sample;
		if (rd_en) sample_s1 <= row_store[rd_addr];
	end

	// Stage 1: tap fetch
	always_ff @(posedge clk) begin
		if (rd_en) begin
			center_s1 <= cmd.issue_center;
			tap_s1    <= cmd.issue_center ? TAP_CENTER : TAP_W'(tap_rom[k_idx]);
		end
	end

	// Stage 2: multiply
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			center_s2 <= center_s1;
			prod_s2   <= PROD_W'(sample_s1) * PROD_W'(tap_s1);
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1;
		end
	end

	// Accumulate: center tap adds, odd taps subtract
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			if (center_s2) acc_q <= acc_q + ACC_W'(prod_s2);
			else acc_q <= acc_q - ACC_W'(prod_s2);
		end
	end

	// Round half up to Q8 and saturate
	assign rnd_sum = acc_q + RND_BIAS;
	assign rnd_q8  = rnd_sum >>> FRAC_DROP;
	always_comb begin
		if (rnd_q8 > SAT_HI) sat_val = OUT_MAX_V;
		else if (rnd_q8 < SAT_LO) sat_val = OUT_MIN_V;
		else sat_val = rnd_q8[OUT_W-1:0];
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			filtered_value <= sat_val;
			out_position   <= pos_q;
			row_index      <= row_q;
		end
	end

endmodule

// ===== rtl/core/sinogram_ramp_filter.sv =====
// Spatial Ram-Lak filter for sinogram rows.
//
// Channels (valid/ready, a transaction completes when both are high):
//   samples : action, position, sample. A load (action 0) writes sample into
//             the row store; a read (action 1) requests the filtered value.
//             Positions at or beyond row_width are dropped without result.
//   results : filtered_value (Q8, saturating), out_position, row_index.
//   cfg     : index 0 row_width, index 1 angle_count; always ready.
//             Write only while the block is idle.
// Throughput: a load is written on acceptance. A read runs one
// multiply-accumulate per cycle over the positions of opposite parity to the
// read position, about row_width/2 steps through one multiplier and one row
// store port; no new item is taken while a read runs, and the next item can
// be taken in the same cycle as the result becomes valid. The row counter
// advances when the last position of a row is read and wraps at angle_count.
// Reset clears the registers to row_width 512, angle_count 180 and the row
// counter to 0; the row store keeps no reset value. A result waits in the
// output register while the receiver stalls; loads and reads keep being
// accepted, and a read that finishes waits until that register is free.
module sinogram_ramp_filter import srf_pkg::*; #(
	parameter int ROW_MAX = 512
) (
	input  logic      clk,
	input  logic      arst_n,
	srf_in_if.sink    samples,
	srf_out_if.source results,
	srf_cfg_if.sink   cfg
);

	srf_cmd_t  cmd;
	srf_stat_t stat;

	assign cfg.ready = 1'b1;

	// Sequencer
	srf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_action (samples.action),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Store, taps and MAC pipeline
	srf_datapath #(
		.ROW_MAX (ROW_MAX)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.position       (samples.position),
		.sample         (samples.sample),
		.cfg_valid      (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.filtered_value (results.filtered_value),
		.out_position   (results.out_position),
		.row_index      (results.row_index)
	);

endmodule

// ===== rtl/core/srf_checker.sv =====
module srf_checker import srf_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [OUT_W-1:0] out_value,
	input logic [POS_W-1:0]        out_pos,
	input logic [ROWIDX_W-1:0]     out_row
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value)
			&& $stable(out_pos) && $stable(out_row))
		else $error("result changed while stalled");

	// A new result only comes from a busy block
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while input side idle");

	// An accepted transaction never yields a result in the cycle after it
	a_no_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(out_valid))
		else $error("result too soon after accept");

	// Reset empties the output
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind sinogram_ramp_filter srf_checker u_srf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_value (results.filtered_value),
	.out_pos   (results.out_position),
	.out_row   (results.row_index)
);

// ===== dv/sinogram_ramp_filter_test.sv =====
module sinogram_ramp_filter_test import srf_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     ROW_LEN       = 512;
	localparam int     ANGLE_CAP     = 1024;
	localparam longint RECIP_Q22     = 424972;  // round(2^22 / pi^2)
	localparam longint CENTER_Q22    = 1048576; // 0.25 in Q22
	localparam longint RES_MAX       = 8388607;
	localparam longint RES_MIN       = -8388608;
	localparam int     SETTLE_CYCLES = ROW_LEN / 2 + 24;
	localparam int     STALL_LIMIT   = 5000;
	localparam int     QUEUE_DEPTH   = 4;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_READ = 1'b1
	} action_e;

	typedef struct packed {
		action_e             action;
		logic [POS_W-1:0]    position;
		logic [SAMPLE_W-1:0] sample;
	} detector_txn_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		logic [POS_W-1:0]        position;
		logic [ROWIDX_W-1:0]     row;
	} filtered_t;

	logic clk;
	logic arst_n;

	srf_in_if  samples_ch ();
	srf_out_if results_ch ();
	srf_cfg_if cfg_ch ();

	sinogram_ramp_filter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	// Shadow of the filter state
	logic [SAMPLE_W-1:0] row_copy [ROW_LEN];
	longint              ramlak_tap [ROW_LEN+1];
	logic [WIDTH_W-1:0]  width_reg;
	logic [ANGLE_W-1:0]  angles_reg;
	logic [ROWIDX_W-1:0] angle_index;

	detector_txn_t pending_items [$];
	filtered_t     filtered_due [$];

	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;
	int hold_off_cycles = 0;
	int err_count       = 0;
	int items_queued    = 0;
	int loads_seen      = 0;
	int reads_seen      = 0;
	int dropped_seen    = 0;
	int values_checked  = 0;
	int row_wraps       = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int active_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > ROW_LEN)
			return ROW_LEN;
		return width_reg;
	endfunction

	function automatic int active_angles();
		if (angles_reg == 0)
			return 1;
		if (angles_reg > ANGLE_CAP)
			return ANGLE_CAP;
		return angles_reg;
	endfunction

	// Fold one accepted transaction into the shadow, queue its filtered value
	function automatic void filter_item(input detector_txn_t it);
		int        w;
		int        off;
		longint    acc;
		longint    q;
		filtered_t r;
		w = active_width();
		if (it.position >= w) begin
			dropped_seen++;
			return;
		end
		if (it.action == ACT_LOAD) begin
			row_copy[it.position] = it.sample;
			loads_seen++;
			return;
		end
		acc = 0;
		for (int m = 0; m < w; m++) begin
			off = (m >= it.position) ? m - it.position : it.position - m;
			acc += longint'(row_copy[m]) * ramlak_tap[off];
		end
		// round half up to Q8, then clamp
		q = (acc + 8192) >>> 14;
		if (q > RES_MAX)
			q = RES_MAX;
		if (q < RES_MIN)
			q = RES_MIN;
		r.value    = q[OUT_W-1:0];
		r.position = it.position;
		r.row      = angle_index;
		filtered_due.push_back(r);
		reads_seen++;
		// last position of the row moves to the next angle
		if (it.position == w - 1) begin
			if (int'(angle_index) + 1 >= active_angles()) begin
				angle_index = '0;
				row_wraps++;
			end else begin
				angle_index = angle_index + 1'b1;
			end
		end
	endfunction

	function automatic int rand_sample();
		case ($urandom_range(7))
			0: return 0;
			1: return 16'hFFFF;
			default: return $urandom_range(16'hFFFF);
		endcase
	endfunction

	// Sample channel driver: holds an item until it is taken
	initial begin : sample_driver
		logic fire;
		samples_ch.valid    = 1'b0;
		samples_ch.action   = ACT_LOAD;
		samples_ch.position = '0;
		samples_ch.sample   = '0;
		forever begin
			@(negedge clk);
			fire = samples_ch.valid && samples_ch.ready;
			@(posedge clk);
			if (fire)
				filter_item(pending_items.pop_front());
			if (fire || !samples_ch.valid) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					samples_ch.valid    <= 1'b1;
					samples_ch.action   <= pending_items[0].action;
					samples_ch.position <= pending_items[0].position;
					samples_ch.sample   <= pending_items[0].sample;
				end else begin
					samples_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result checker and ready generation
	initial begin : result_checker
		logic      fire;
		filtered_t got;
		filtered_t want;
		results_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			fire         = results_ch.valid && results_ch.ready;
			got.value    = results_ch.filtered_value;
			got.position = results_ch.out_position;
			got.row      = results_ch.row_index;
			@(posedge clk);
			if (fire) begin
				if (filtered_due.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result, position %0d value %0d row %0d",
						$time, got.position, got.value, got.row);
				end else begin
					want = filtered_due.pop_front();
					values_checked++;
					if (got.value !== want.value) begin
						err_count++;
						$display("%0t: filtered_value at position %0d: expected %0d actual %0d",
							$time, want.position, want.value, got.value);
					end
					if (got.position !== want.position) begin
						err_count++;
						$display("%0t: out_position: expected %0d actual %0d",
							$time, want.position, got.position);
					end
					if (got.row !== want.row) begin
						err_count++;
						$display("%0t: row_index at position %0d: expected %0d actual %0d",
							$time, want.position, want.row, got.row);
					end
				end
			end
			if (hold_off_cycles > 0) begin
				results_ch.ready <= 1'b0;
				hold_off_cycles--;
			end else begin
				results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: ends the run when no channel moves for too long
	initial begin : stall_watch
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if ((samples_ch.valid && samples_ch.ready) ||
			    (results_ch.valid && results_ch.ready) ||
			    (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send(input action_e act, input int pos, input int smp);
		detector_txn_t it;
		it.action   = act;
		it.position = pos[POS_W-1:0];
		it.sample   = smp[SAMPLE_W-1:0];
		do @(negedge clk); while (pending_items.size() >= QUEUE_DEPTH);
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic drain_results();
		while (pending_items.size() != 0 || filtered_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic settle();
		drain_results();
		// a dropped item may still be in flight
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value[CFG_DATA_W-1:0];
		do @(negedge clk); while (!cfg_ch.ready);
		@(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_ROW_WIDTH)
			width_reg = value[WIDTH_W-1:0];
		else
			angles_reg = value[ANGLE_W-1:0];
	endtask

	task automatic configure(input int width, input int angles);
		settle();
		reg_write(REG_ROW_WIDTH, width);
		reg_write(REG_ANGLE_COUNT, angles);
	endtask

	// Full row at reset width: even positions full scale, odd zero, so
	// even reads peak positive and odd reads peak negative
	task automatic test_full_row();
		int picks [6] = '{0, 1, 2, 255, 510, 511};
		for (int p = 0; p < ROW_LEN; p++)
			send(ACT_LOAD, p, (p % 2 == 0) ? 16'hFFFF : 0);
		foreach (picks[i])
			send(ACT_READ, picks[i], $urandom_range(16'hFFFF));
	endtask

	// Width clamping and positions past the row end
	task automatic test_width_clamp();
		configure(0, 180);
		send(ACT_LOAD, 0, 12345);
		send(ACT_READ, 0, 0);
		send(ACT_READ, 1, 0);
		send(ACT_READ, 511, 16'hFFFF);
		send(ACT_LOAD, 5, 16'hFFFF);
		send(ACT_READ, 0, 0);
		configure(1023, 180);
		send(ACT_READ, 5, 0);
		send(ACT_READ, 511, 0);
	endtask

	// Angle wrap, a count written below the current row, clamped counts
	task automatic test_angle_wrap();
		configure(4, 3);
		for (int p = 0; p < 4; p++)
			send(ACT_LOAD, p, rand_sample());
		repeat (4) send(ACT_READ, 3, 0);
		for (int p = 0; p < 4; p++)
			send(ACT_READ, p, 0);
		configure(4, 8);
		while (angle_index != 6) begin
			send(ACT_READ, 3, 0);
			drain_results();
		end
		configure(4, 2);
		repeat (3) send(ACT_READ, 3, 0);
		configure(4, 0);
		repeat (3) send(ACT_READ, 3, 0);
	endtask

	// One-sample rows through the full 1024-angle range (count clamped)
	task automatic test_counter_rollover();
		configure(1, 2047);
		send(ACT_LOAD, 0, rand_sample());
		for (int i = 0; i < ANGLE_CAP + 6; i++) begin
			if (i % 64 == 0) begin
				send(ACT_LOAD, 0, rand_sample());
				send(action_e'($urandom_range(1)), $urandom_range(511), $urandom_range(16'hFFFF));
			end
			send(ACT_READ, 0, 0);
		end
	endtask

	// Receiver holds off while reads keep coming, then the sender waits out
	// every result before going on
	task automatic test_backpressure();
		configure(64, 1024);
		@(negedge clk);
		hold_off_cycles = 600;
		repeat (16) begin
			send(ACT_READ, $urandom_range(63), 0);
			send(ACT_LOAD, $urandom_range(63), rand_sample());
		end
		drain_results();
		repeat (8) send(ACT_READ, $urandom_range(63), 0);
		drain_results();
	endtask

	// Random phases: mostly whole rows loaded then read, plus loose items
	task automatic test_random_rows(input int n_items);
		int first;
		int w;
		int n_load;
		int start;
		first = items_queued;
		while (items_queued - first < n_items) begin
			case ($urandom_range(9))
				0: w = $urandom_range(2);
				1: w = $urandom_range(65, 1023);
				default: w = $urandom_range(3, 40);
			endcase
			case ($urandom_range(5))
				0: configure(w, $urandom_range(3));
				1: configure(w, ANGLE_CAP);
				2: configure(w, $urandom_range(ANGLE_CAP + 1, 2047));
				default: configure(w, $urandom_range(4, 24));
			endcase
			w = active_width();
			repeat ($urandom_range(2, 5)) begin
				if ($urandom_range(3) != 0) begin
					// whole rows are preloaded, so wide rows only refresh a window
					n_load = (w <= 64) ? w : 32;
					start  = $urandom_range(w - 1);
					for (int p = 0; p < n_load; p++)
						send(ACT_LOAD, (start + p) % w, rand_sample());
					if (w <= 64) begin
						for (int p = 0; p < w; p++)
							send(ACT_READ, p, $urandom_range(16'hFFFF));
					end else begin
						repeat (6) send(ACT_READ, $urandom_range(w - 2), 0);
						send(ACT_READ, w - 1, 0);
					end
				end else begin
					repeat ($urandom_range(4, 20))
						send(action_e'($urandom_range(1)), $urandom_range(511),
							$urandom_range(16'hFFFF));
				end
			end
		end
	endtask

	initial begin
		arst_n       = 1'b1;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ROW_WIDTH;
		cfg_ch.data  = '0;
		width_reg    = 10'd512;
		angles_reg   = 11'd180;
		angle_index  = '0;
		// Ram-Lak taps in Q22: quarter at center, zero at even offsets
		ramlak_tap[0] = CENTER_Q22;
		for (longint n = 1; n <= ROW_LEN; n++) begin
			if (n % 2 == 0)
				ramlak_tap[n] = 0;
			else
				ramlak_tap[n] = -((2 * RECIP_Q22 + n * n) / (2 * n * n));
		end
		// reset falls after time zero so every flop sees the edge
		#1 arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct  = 38;
		recv_stall_pct = 87;
		test_full_row();
		test_width_clamp();
		test_angle_wrap();
		test_random_rows(40);

		send_idle_pct  = 87;
		recv_stall_pct = 38;
		test_counter_rollover();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_backpressure();

		settle();
		$display("Checked %0d filtered values from %0d reads and %0d loads; %0d items fell past the row end.",
			values_checked, reads_seen, loads_seen, dropped_seen);
		$display("Row widths from 1 to 512 with clamped settings; the angle counter wrapped %0d times.",
			row_wraps);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
